// ===== hw/rtl/tksel_pkg.sv =====
// ----------------------------------------------------------------------------
// tksel_pkg
// Shared types, constants and the score ordering function of the top-k
// class selector.
// ----------------------------------------------------------------------------
package tksel_pkg;

    localparam int TOP_K_DEFAULT       = 8;
    localparam int MAX_CLASSES_DEFAULT = 1024;
    localparam int QUEUE_DEPTH_DEFAULT = 2;

    localparam int SCORE_W       = 32;
    localparam int CLASS_INDEX_W = 10;
    localparam int KEEP_W        = 4;
    localparam int FMT_W         = 2;
    localparam int MAX_RESULTS   = 8;
    localparam int RES_CNT_W     = $clog2(MAX_RESULTS + 1);

    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 32;

    localparam logic [CFG_INDEX_W-1:0] CFG_KEEP_COUNT   = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] CFG_SCORE_FORMAT = CFG_INDEX_W'(1);

    localparam logic [FMT_W-1:0] FMT_UNSIGNED = FMT_W'(0);
    localparam logic [FMT_W-1:0] FMT_SIGNED   = FMT_W'(1);
    localparam logic [FMT_W-1:0] FMT_FLOAT    = FMT_W'(2);

    localparam logic [KEEP_W-1:0] KEEP_COUNT_RESET   = KEEP_W'(5);
    localparam logic [FMT_W-1:0]  SCORE_FORMAT_RESET = FMT_FLOAT;

    typedef struct packed {
        logic [SCORE_W-1:0] score_bits;
        logic               last_in_sample;
    } tksel_in_t;

    typedef struct packed {
        logic [CLASS_INDEX_W-1:0] class_index;
        logic [SCORE_W-1:0]       class_score;
        logic                     last_of_run;
    } tksel_out_t;

    // classified score handed from front to back
    typedef struct packed {
        logic [SCORE_W-1:0] score;
        logic [SCORE_W-1:0] key;
        logic               rank;
        logic               last;
    } tksel_cls_t;

    typedef enum logic [1:0] {
        ST_INSERT,
        ST_COUNT,
        ST_EMIT
    } tksel_state_t;

    // unsigned key whose order matches the score order
    function automatic logic [SCORE_W-1:0] order_key(input logic [SCORE_W-1:0] bits,
                                                     input logic [FMT_W-1:0]   fmt);
        logic [SCORE_W-1:0] b;
        logic [SCORE_W-1:0] k;
        b = bits;
        k = bits;
        unique case (fmt)
            FMT_UNSIGNED: k = bits;
            FMT_SIGNED:   k = {~bits[SCORE_W-1], bits[SCORE_W-2:0]};
            default: begin
                if (bits[30:23] == 8'hFF && bits[22:0] != 23'd0) begin
                    k = '0;
                end else begin
                    if (bits[30:0] == 31'd0) begin
                        b = '0;
                    end
                    if (b[SCORE_W-1]) begin
                        k = ~b;
                    end else begin
                        k = {1'b1, b[SCORE_W-2:0]};
                    end
                end
            end
        endcase
        return k;
    endfunction

endpackage

// ===== hw/rtl/tksel_queue.sv =====
// ----------------------------------------------------------------------------
// tksel_queue
// Short first-in first-out queue between the classifying front and the
// ranking back.
// ----------------------------------------------------------------------------
module tksel_queue
    import tksel_pkg::*;
#(
    parameter int DATA_W = 8,
    parameter int DEPTH  = QUEUE_DEPTH_DEFAULT
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [DATA_W-1:0] in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [DATA_W-1:0] out_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0]  wptr_reg, wptr_next;
    logic [PTR_W-1:0]  rptr_reg, rptr_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              push, pop;

    assign in_ready  = (cnt_reg != CNT_W'(DEPTH));
    assign out_valid = (cnt_reg != '0);
    assign out_data  = mem_reg[rptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        wptr_next = wptr_reg;
        rptr_next = rptr_reg;
        cnt_next  = cnt_reg;
        if (push) begin
            wptr_next = (wptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
        end
        if (pop) begin
            rptr_next = (rptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end else begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wptr_reg] <= in_data;
        end
    end

endmodule

// ===== hw/rtl/tksel_front.sv =====
// ----------------------------------------------------------------------------
// tksel_front
// Accepts score transactions, numbers them within the sample, computes the
// ordering key and marks scores past the class limit as not ranked.
// ----------------------------------------------------------------------------
module tksel_front
    import tksel_pkg::*;
#(
    parameter int MAX_CLASSES = MAX_CLASSES_DEFAULT,
    parameter int IDX_W       = $clog2(MAX_CLASSES)
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic [FMT_W-1:0] score_format,
    input  logic             s_valid,
    output logic             s_ready,
    input  tksel_in_t        s_data,
    output logic             q_valid,
    input  logic             q_ready,
    output tksel_cls_t       q_cls,
    output logic [IDX_W-1:0] q_index
);

    localparam int CNT_W = IDX_W + 1;

    logic [CNT_W-1:0] idx_reg, idx_next;
    logic             rank;
    logic             accept;

    assign rank    = (idx_reg < CNT_W'(MAX_CLASSES));
    assign s_ready = q_ready;
    assign q_valid = s_valid;
    assign accept  = s_valid && q_ready;

    assign q_cls.score = s_data.score_bits;
    assign q_cls.key   = order_key(s_data.score_bits, score_format);
    assign q_cls.rank  = rank;
    assign q_cls.last  = s_data.last_in_sample;
    assign q_index     = idx_reg[IDX_W-1:0];

    always_comb begin
        idx_next = idx_reg;
        if (accept) begin
            if (s_data.last_in_sample) begin
                idx_next = '0;
            end else if (rank) begin
                idx_next = idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg <= '0;
        end else begin
            idx_reg <= idx_next;
        end
    end

endmodule

// ===== hw/rtl/tksel_back.sv =====
// ----------------------------------------------------------------------------
// tksel_back
// Keeps the sorted best-score list with parallel compare-and-insert and
// drains the ranked results through an output register at sample end.
// ----------------------------------------------------------------------------
module tksel_back
    import tksel_pkg::*;
#(
    parameter int TOP_K = TOP_K_DEFAULT,
    parameter int IDX_W = 10
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [FMT_W-1:0]  score_format,
    input  logic [KEEP_W-1:0] keep_count,
    input  logic              q_valid,
    output logic              q_ready,
    input  tksel_cls_t        q_cls,
    input  logic [IDX_W-1:0]  q_index,
    output logic              m_valid,
    input  logic              m_ready,
    output tksel_out_t        m_data
);

    localparam int CNT_W = $clog2(TOP_K + 1);
    localparam int CMP_W = (CNT_W > KEEP_W) ? CNT_W : KEEP_W;

    logic [SCORE_W-1:0] score_reg [TOP_K];
    logic [SCORE_W-1:0] score_next [TOP_K];
    logic [IDX_W-1:0]   idx_reg [TOP_K];
    logic [IDX_W-1:0]   idx_next [TOP_K];
    logic [SCORE_W-1:0] skey [TOP_K];
    logic [TOP_K-1:0]   gt;

    tksel_state_t       state_reg, state_next;
    logic [CNT_W-1:0]   filled_reg, filled_next;
    logic [RES_CNT_W-1:0] rem_reg, rem_next;
    logic               m_valid_reg, m_valid_next;
    tksel_out_t         m_data_reg, m_data_next;

    logic [CNT_W-1:0]   pos;
    logic [CMP_W-1:0]   n_sel;
    logic               out_free;

    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;
    assign out_free = !m_valid_reg || m_ready;
    assign q_ready  = (state_reg == ST_INSERT);

    always_comb begin
        for (int j = 0; j < TOP_K; j++) begin
            skey[j] = order_key(score_reg[j], score_format);
            gt[j]   = (CNT_W'(j) < filled_reg) && (q_cls.key > skey[j]);
        end
        pos = filled_reg;
        for (int j = TOP_K - 1; j >= 0; j--) begin
            if (gt[j]) begin
                pos = CNT_W'(j);
            end
        end
    end

    // results for this sample: min(keep_count, TOP_K, filled, 8)
    always_comb begin
        n_sel = CMP_W'(keep_count);
        if (n_sel > CMP_W'(TOP_K)) begin
            n_sel = CMP_W'(TOP_K);
        end
        if (n_sel > CMP_W'(filled_reg)) begin
            n_sel = CMP_W'(filled_reg);
        end
        if (n_sel > CMP_W'(MAX_RESULTS)) begin
            n_sel = CMP_W'(MAX_RESULTS);
        end
    end

    always_comb begin
        state_next   = state_reg;
        filled_next  = filled_reg;
        rem_next     = rem_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        for (int j = 0; j < TOP_K; j++) begin
            score_next[j] = score_reg[j];
            idx_next[j]   = idx_reg[j];
        end
        unique case (state_reg)
            ST_INSERT: begin
                if (q_valid) begin
                    if (q_cls.rank && pos < CNT_W'(TOP_K)) begin
                        for (int j = 1; j < TOP_K; j++) begin
                            if (CNT_W'(j) > pos) begin
                                score_next[j] = score_reg[j-1];
                                idx_next[j]   = idx_reg[j-1];
                            end
                        end
                        for (int j = 0; j < TOP_K; j++) begin
                            if (CNT_W'(j) == pos) begin
                                score_next[j] = q_cls.score;
                                idx_next[j]   = q_index;
                            end
                        end
                        if (filled_reg < CNT_W'(TOP_K)) begin
                            filled_next = filled_reg + 1'b1;
                        end
                    end
                    if (q_cls.last) begin
                        state_next = ST_COUNT;
                    end
                end
            end
            ST_COUNT: begin
                rem_next = RES_CNT_W'(n_sel);
                if (n_sel == '0) begin
                    filled_next = '0;
                    state_next  = ST_INSERT;
                end else begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    m_valid_next            = 1'b1;
                    m_data_next.class_index = CLASS_INDEX_W'(idx_reg[0]);
                    m_data_next.class_score = score_reg[0];
                    m_data_next.last_of_run = (rem_reg == RES_CNT_W'(1));
                    for (int j = 0; j < TOP_K - 1; j++) begin
                        score_next[j] = score_reg[j+1];
                        idx_next[j]   = idx_reg[j+1];
                    end
                    rem_next = rem_reg - 1'b1;
                    if (rem_reg == RES_CNT_W'(1)) begin
                        filled_next = '0;
                        state_next  = ST_INSERT;
                    end
                end
            end
            default: state_next = ST_INSERT;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_INSERT;
            filled_reg  <= '0;
            rem_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            filled_reg  <= filled_next;
            rem_reg     <= rem_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
        for (int j = 0; j < TOP_K; j++) begin
            score_reg[j] <= score_next[j];
            idx_reg[j]   <= idx_next[j];
        end
    end

endmodule

// ===== hw/rtl/top_k_class_selector_unit.sv =====
// ----------------------------------------------------------------------------
// top_k_class_selector_unit
// Streaming top-k class selection: keeps the best scores of a sample sorted
// and reports them best first when the sample ends.
// Drain: a sample's last score passes the queue into the list; the back then
//   counts results in ST_COUNT and outputs them in ST_EMIT, one per cycle
//   while m_ready is high. Throughput: one score per cycle while the back
//   inserts; a full queue stalls input while the single list registers drain.
// Reset: synchronous active-low aresetn clears list fill, counters and queue;
//   keep_count resets to 5 and score_format to float32.
// ----------------------------------------------------------------------------
module top_k_class_selector_unit
    import tksel_pkg::*;
#(
    parameter int TOP_K       = TOP_K_DEFAULT,
    parameter int MAX_CLASSES = MAX_CLASSES_DEFAULT
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  tksel_in_t              s_data,
    output logic                   m_valid,
    input  logic                   m_ready,
    output tksel_out_t             m_data,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int IDX_W  = $clog2(MAX_CLASSES);
    localparam int QDAT_W = $bits(tksel_cls_t) + IDX_W;

    logic [KEEP_W-1:0] keep_reg, keep_next;
    logic [FMT_W-1:0]  fmt_reg, fmt_next;

    logic              fq_valid, fq_ready;
    tksel_cls_t        fq_cls;
    logic [IDX_W-1:0]  fq_index;
    logic              qb_valid, qb_ready;
    logic [QDAT_W-1:0] qb_data;
    tksel_cls_t        qb_cls;
    logic [IDX_W-1:0]  qb_index;

    assign cfg_ready = 1'b1;

    always_comb begin
        keep_next = keep_reg;
        fmt_next  = fmt_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                CFG_KEEP_COUNT:   keep_next = cfg_data[KEEP_W-1:0];
                CFG_SCORE_FORMAT: fmt_next  = cfg_data[FMT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            keep_reg <= KEEP_COUNT_RESET;
            fmt_reg  <= SCORE_FORMAT_RESET;
        end else begin
            keep_reg <= keep_next;
            fmt_reg  <= fmt_next;
        end
    end

    tksel_front #(
        .MAX_CLASSES (MAX_CLASSES),
        .IDX_W       (IDX_W)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .score_format (fmt_reg),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data       (s_data),
        .q_valid      (fq_valid),
        .q_ready      (fq_ready),
        .q_cls        (fq_cls),
        .q_index      (fq_index)
    );

    tksel_queue #(
        .DATA_W (QDAT_W),
        .DEPTH  (QUEUE_DEPTH_DEFAULT)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_data   ({fq_cls, fq_index}),
        .out_valid (qb_valid),
        .out_ready (qb_ready),
        .out_data  (qb_data)
    );

    assign qb_cls   = qb_data[QDAT_W-1:IDX_W];
    assign qb_index = qb_data[IDX_W-1:0];

    tksel_back #(
        .TOP_K (TOP_K),
        .IDX_W (IDX_W)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .score_format (fmt_reg),
        .keep_count   (keep_reg),
        .q_valid      (qb_valid),
        .q_ready      (qb_ready),
        .q_cls        (qb_cls),
        .q_index      (qb_index),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_data       (m_data)
    );

endmodule
